@@ sv/ts_packet_payload_extractor_macros.svh @@
// Assertion macros shared by the transport stream payload extractor modules.
`ifndef TS_PACKET_PAYLOAD_EXTRACTOR_MACROS_SVH
`define TS_PACKET_PAYLOAD_EXTRACTOR_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define TSPE_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define TSPE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TSPE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tspe_pkg.sv @@
// Package with the constants, codes and result type of the transport stream payload extractor.
`default_nettype none

package tspe_pkg;

  localparam int PACKET_BYTES = 188;
  localparam int POS_W = 8;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(4);

  localparam int DISCON_COUNT_BITS_DEFAULT = 16;
  localparam int DISCON_OUT_W = 16;

  localparam int PID_W = 13;
  localparam logic [PID_W-1:0] WANTED_PID_RESET = 13'h1102;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = PID_W;
  localparam logic [CFG_INDEX_W-1:0] REG_WANTED_PID = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PID_FILTER_ENABLE = 1'd1;

  localparam int STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_PASS = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOPAYLOAD = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TERR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADADAPT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PIDMISS = 3'd4;

  localparam int TDATA_W = 32;
  localparam int TUSER_W = 2;

  typedef struct packed {
    logic                    out_valid;
    logic [7:0]              payload_byte;
    logic                    unit_start;
    logic                    packet_done;
    logic [STATUS_W-1:0]     packet_status;
    logic [DISCON_OUT_W-1:0] discon_count;
  } tspe_result_t;

endpackage

`default_nettype wire

@@ sv/tspe_parser.sv @@
// Header parser, continuity check and payload selection for one transport stream word.
`default_nettype none

`include "ts_packet_payload_extractor_macros.svh"

module tspe_parser
  import tspe_pkg::*;
#(
  parameter int DISCON_COUNT_BITS = DISCON_COUNT_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [7:0]         data_byte,
  input  wire logic               packet_first,
  input  wire logic [PID_W-1:0]   wanted_pid,
  input  wire logic               pid_filter_enable,
  output tspe_result_t            result
);

  logic [POS_W-1:0]             byte_position, byte_position_next;
  logic                         flag_err, flag_err_next;
  logic                         flag_pusi, flag_pusi_next;
  logic                         flag_adapt, flag_adapt_next;
  logic                         flag_payload, flag_payload_next;
  logic [PID_W-1:0]             packet_pid, packet_pid_next;
  logic [POS_W-1:0]             payload_offset, payload_offset_next;
  logic [3:0]                   last_continuity, last_continuity_next;
  logic                         continuity_seen, continuity_seen_next;
  logic [DISCON_COUNT_BITS-1:0] discon_total, discon_total_next;
  logic [STATUS_W-1:0]          packet_verdict, packet_verdict_next;
  logic [POS_W-1:0]             pos;
  logic [POS_W:0]               adapt_end;
  logic [DISCON_OUT_W-1:0]      discon_low;
  logic                         emit;
  logic                         done;

  generate
    if (DISCON_COUNT_BITS >= DISCON_OUT_W) begin : g_trunc
      assign discon_low = discon_total_next[DISCON_OUT_W-1:0];
    end else begin : g_ext
      assign discon_low = {{(DISCON_OUT_W - DISCON_COUNT_BITS){1'b0}}, discon_total_next};
    end
  endgenerate

  always_comb begin
    pos = packet_first ? '0 : byte_position;
    adapt_end = (POS_W + 1)'(5) + {1'b0, data_byte};
    flag_err_next = flag_err;
    flag_pusi_next = flag_pusi;
    flag_adapt_next = flag_adapt;
    flag_payload_next = flag_payload;
    packet_pid_next = packet_pid;
    payload_offset_next = payload_offset;
    last_continuity_next = last_continuity;
    continuity_seen_next = continuity_seen;
    discon_total_next = discon_total;
    packet_verdict_next = packet_verdict;

    if (pos == POS_W'(0)) begin
      flag_err_next = 1'b0;
      flag_pusi_next = 1'b0;
      flag_adapt_next = 1'b0;
      flag_payload_next = 1'b0;
      packet_pid_next = '0;
      payload_offset_next = '0;
      packet_verdict_next = ST_PASS;
    end else if (pos == POS_W'(1)) begin
      flag_err_next = data_byte[7];
      flag_pusi_next = data_byte[6];
      packet_pid_next = {data_byte[4:0], 8'h00};
    end else if (pos == POS_W'(2)) begin
      packet_pid_next = {packet_pid[PID_W-1:8], data_byte};
    end else if (pos == POS_W'(3)) begin
      flag_adapt_next = data_byte[5];
      flag_payload_next = data_byte[4];
      if (pid_filter_enable && (packet_pid != wanted_pid)) begin
        packet_verdict_next = ST_PIDMISS;
      end else if (flag_err) begin
        packet_verdict_next = ST_TERR;
      end else begin
        if (continuity_seen && (4'(last_continuity + 4'd1) != data_byte[3:0])) begin
          if (discon_total != '1) begin
            discon_total_next = discon_total + DISCON_COUNT_BITS'(1);
          end
        end
        last_continuity_next = data_byte[3:0];
        continuity_seen_next = 1'b1;
        if (!data_byte[4]) begin
          packet_verdict_next = ST_NOPAYLOAD;
        end else begin
          packet_verdict_next = ST_PASS;
          payload_offset_next = data_byte[5] ? POS_W'(5) : POS_W'(4);
        end
      end
    end else if (pos == HEADER_BYTES) begin
      if ((packet_verdict == ST_PASS) && flag_adapt) begin
        if (adapt_end > {1'b0, LAST_POS}) begin
          packet_verdict_next = ST_BADADAPT;
        end else begin
          payload_offset_next = adapt_end[POS_W-1:0];
        end
      end
    end

    emit = (pos >= HEADER_BYTES) && (packet_verdict_next == ST_PASS)
           && (pos >= payload_offset_next);
    done = (pos == LAST_POS);
    byte_position_next = done ? '0 : pos + POS_W'(1);

    result.out_valid = emit;
    result.payload_byte = emit ? data_byte : 8'h00;
    result.unit_start = (emit || done) ? flag_pusi_next : 1'b0;
    result.packet_done = done;
    result.packet_status = done ? packet_verdict_next : ST_PASS;
    result.discon_count = discon_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      flag_err <= 1'b0;
      flag_pusi <= 1'b0;
      flag_adapt <= 1'b0;
      flag_payload <= 1'b0;
      packet_pid <= '0;
      payload_offset <= '0;
      last_continuity <= '0;
      continuity_seen <= 1'b0;
      discon_total <= '0;
      packet_verdict <= ST_PASS;
    end else if (step) begin
      byte_position <= byte_position_next;
      flag_err <= flag_err_next;
      flag_pusi <= flag_pusi_next;
      flag_adapt <= flag_adapt_next;
      flag_payload <= flag_payload_next;
      packet_pid <= packet_pid_next;
      payload_offset <= payload_offset_next;
      last_continuity <= last_continuity_next;
      continuity_seen <= continuity_seen_next;
      discon_total <= discon_total_next;
      packet_verdict <= packet_verdict_next;
    end
  end

  `TSPE_ASSERT(a_pos_range, byte_position <= LAST_POS, "byte position beyond the packet")
  `TSPE_ASSERT_NEXT(a_discon_monotonic, !rst, discon_total >= $past(discon_total), "discontinuity count fell")
  `TSPE_ASSERT_IMP(a_emit_after_header, step && result.out_valid, pos >= HEADER_BYTES, "payload word inside the header")

endmodule

`default_nettype wire

@@ sv/ts_packet_payload_extractor.sv @@
// Top level of the transport stream PID filter and payload extractor.
// The block takes one stream word per clock and returns exactly one result word for each, in the
// next cycle, through a single output register; a new word is taken whenever that register is
// empty or is being read in the same cycle, so the sustained rate is one word per clock. Every
// packet has 188 words; tuser marks word 0 and realigns the position count, and without it the
// count simply wraps. Payload words carry out_valid, the packet status appears on the word with
// tlast, and the discontinuity count is present on every result word.
`default_nettype none

`include "ts_packet_payload_extractor_macros.svh"

module ts_packet_payload_extractor
  import tspe_pkg::*;
#(
  parameter int DISCON_COUNT_BITS = DISCON_COUNT_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // [7:0] data_byte
  input  wire logic                   s_axis_tuser,   // [0] packet_first
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [TDATA_W-1:0]     m_axis_tdata,   // [7:0] payload_byte, [10:8] packet_status,
                                                      // [26:11] discon_count, [31:27] zero
  output      logic [TUSER_W-1:0]     m_axis_tuser,   // [0] out_valid, [1] unit_start
  output      logic                   m_axis_tlast,   // packet_done
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [PID_W-1:0] wanted_pid;
  logic             pid_filter_enable;
  logic             step;
  tspe_result_t     result;
  tspe_result_t     out_reg;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_pid <= WANTED_PID_RESET;
      pid_filter_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WANTED_PID: begin
          wanted_pid <= cfg_data[PID_W-1:0];
        end
        REG_PID_FILTER_ENABLE: begin
          pid_filter_enable <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  tspe_parser #(
    .DISCON_COUNT_BITS(DISCON_COUNT_BITS)
  ) u_parser (
    .clk(clk),
    .rst(rst),
    .step(step),
    .data_byte(s_axis_tdata),
    .packet_first(s_axis_tuser),
    .wanted_pid(wanted_pid),
    .pid_filter_enable(pid_filter_enable),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= result;
    end
  end

  assign m_axis_tdata = {{(TDATA_W - DISCON_OUT_W - STATUS_W - 8){1'b0}},
                         out_reg.discon_count, out_reg.packet_status, out_reg.payload_byte};
  assign m_axis_tuser = {out_reg.unit_start, out_reg.out_valid};
  assign m_axis_tlast = out_reg.packet_done;

  `TSPE_ASSERT_IMP(a_payload_pass, m_axis_tvalid && m_axis_tuser[0] && m_axis_tlast, m_axis_tdata[10:8] == ST_PASS, "payload word with a failing status")
  `TSPE_ASSERT_IMP(a_idle_byte_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[7:0] == 8'h00, "data byte set on a non-payload word")
  `TSPE_ASSERT_IMP(a_unit_start_gated, m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tlast, !m_axis_tuser[1], "unit start flag on a plain word")

endmodule

`default_nettype wire

@@ verif/ts_packet_payload_extractor_checker.sv @@
// Checker for the transport stream payload extractor: predicts each result word and compares it.
`timescale 1ns / 1ps

module ts_packet_payload_extractor_checker
  import tspe_pkg::*;
#(
  parameter int DISCON_COUNT_BITS = DISCON_COUNT_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [TDATA_W-1:0]     m_axis_tdata,
  input  logic [TUSER_W-1:0]     m_axis_tuser,
  input  logic                   m_axis_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     results_pending
);

  localparam int FLAG_TERR = 7;
  localparam int FLAG_UNIT_START = 6;
  localparam int FLAG_ADAPT = 5;
  localparam int FLAG_PAYLOAD = 4;

  logic [PID_W-1:0]             pid_wanted;
  logic                         filter_on;
  logic [POS_W-1:0]             next_pos;
  logic [7:0]                   flags;
  logic [PID_W-1:0]             pid_seen;
  logic [POS_W-1:0]             payload_start;
  logic [3:0]                   last_cc;
  logic                         cc_seen;
  logic [DISCON_COUNT_BITS-1:0] discon;
  logic [STATUS_W-1:0]          verdict;
  tspe_result_t                 results_due[$];

  function automatic tspe_result_t parse_stream_byte(input logic [7:0] b, input logic first);
    tspe_result_t     r;
    logic [POS_W-1:0] pos;
    logic [8:0]       adapt_end;
    logic             valid;
    logic             done;
    pos = first ? '0 : next_pos;
    if (pos > LAST_POS) pos = '0;
    case (pos)
      8'd0: begin
        flags = '0;
        pid_seen = '0;
        payload_start = '0;
        verdict = ST_PASS;
      end
      8'd1: begin
        flags = b & 8'hc0;
        pid_seen = {b[4:0], 8'h00};
      end
      8'd2: begin
        pid_seen[7:0] = b;
      end
      8'd3: begin
        flags = flags | (b & 8'h30);
        if (filter_on && pid_seen != pid_wanted) begin
          verdict = ST_PIDMISS;
        end else if (flags[FLAG_TERR]) begin
          verdict = ST_TERR;
        end else begin
          if (cc_seen && 4'(last_cc + 4'd1) != b[3:0] && discon != '1)
            discon = discon + DISCON_COUNT_BITS'(1);
          last_cc = b[3:0];
          cc_seen = 1'b1;
          if (!flags[FLAG_PAYLOAD]) begin
            verdict = ST_NOPAYLOAD;
          end else begin
            verdict = ST_PASS;
            payload_start = flags[FLAG_ADAPT] ? HEADER_BYTES + 8'd1 : HEADER_BYTES;
          end
        end
      end
      8'd4: begin
        if (verdict == ST_PASS && flags[FLAG_ADAPT]) begin
          adapt_end = 9'd5 + {1'b0, b};
          if (adapt_end > {1'b0, LAST_POS}) verdict = ST_BADADAPT;
          else payload_start = adapt_end[7:0];
        end
      end
      default: ;
    endcase
    valid = pos >= HEADER_BYTES && verdict == ST_PASS && pos >= payload_start;
    done = pos == LAST_POS;
    r.out_valid = valid;
    r.payload_byte = valid ? b : 8'h00;
    r.unit_start = (valid || done) ? flags[FLAG_UNIT_START] : 1'b0;
    r.packet_done = done;
    r.packet_status = done ? verdict : '0;
    r.discon_count = DISCON_OUT_W'(discon);
    next_pos = (pos == LAST_POS) ? '0 : pos + POS_W'(1);
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] expected,
                            input logic [31:0] actual);
    if (actual !== expected) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, field, expected, actual);
    end
  endtask

  always @(posedge clk) begin : watch
    tspe_result_t want;
    if (rst) begin
      pid_wanted = WANTED_PID_RESET;
      filter_on = 1'b1;
      next_pos = '0;
      flags = '0;
      pid_seen = '0;
      payload_start = '0;
      last_cc = '0;
      cc_seen = 1'b0;
      discon = '0;
      verdict = ST_PASS;
      mismatches = 0;
      results_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, got tdata %0h", $time,
                   m_axis_tdata);
        end else begin
          want = results_due.pop_front();
          flag_field("out_valid", 32'(want.out_valid), 32'(m_axis_tuser[0]));
          flag_field("payload_byte", 32'(want.payload_byte), 32'(m_axis_tdata[7:0]));
          flag_field("unit_start", 32'(want.unit_start), 32'(m_axis_tuser[1]));
          flag_field("packet_done", 32'(want.packet_done), 32'(m_axis_tlast));
          flag_field("packet_status", 32'(want.packet_status), 32'(m_axis_tdata[10:8]));
          flag_field("discon_count", 32'(want.discon_count), 32'(m_axis_tdata[26:11]));
          flag_field("tdata padding", 32'(0), 32'(m_axis_tdata[TDATA_W-1:27]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        results_due.push_back(parse_stream_byte(s_axis_tdata, s_axis_tuser));
      if (cfg_we) begin
        if (cfg_index == REG_WANTED_PID) pid_wanted = cfg_data[PID_W-1:0];
        else if (cfg_index == REG_PID_FILTER_ENABLE) filter_on = cfg_data[0];
      end
    end
    results_pending = results_due.size();
  end

endmodule

@@ verif/tb_ts_packet_payload_extractor.sv @@
// Testbench top for the transport stream payload extractor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_ts_packet_payload_extractor;
  import tspe_pkg::*;

  // A discontinuity counter narrower than the output exercises the zero-extended count.
  localparam int DISCON_BITS = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_WORDS = 150;
  localparam logic [7:0] SYNC_BYTE = 8'h47;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_W-1:0]     m_axis_tdata;
  logic [TUSER_W-1:0]     m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatches;
  int                     results_pending;

  bit                     sender_gaps;
  bit                     reader_gaps;
  logic [PID_W-1:0]       pid_now;
  logic [3:0]             cc_next;
  int                     words_sent;

  ts_packet_payload_extractor #(
    .DISCON_COUNT_BITS(DISCON_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  ts_packet_payload_extractor_checker #(
    .DISCON_COUNT_BITS(DISCON_BITS)
  ) stream_check (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic push_word(input logic [7:0] b, input logic first);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tuser = first;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_WANTED_PID) pid_now = value[PID_W-1:0];
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [PID_W-1:0] pid, input bit terr, input bit pusi,
                             input logic [1:0] field_ctl, input logic [3:0] cc,
                             input logic [7:0] adapt_len, input int words, input bit marked);
    logic [7:0] b;
    for (int i = 0; i < words; i++) begin
      case (i)
        0: b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : SYNC_BYTE;
        1: b = {terr, pusi, 1'($urandom), pid[12:8]};
        2: b = pid[7:0];
        3: b = {2'($urandom), field_ctl, cc};
        4: b = field_ctl[1] ? adapt_len : 8'($urandom);
        default: b = 8'($urandom);
      endcase
      push_word(b, marked && i == 0);
    end
  endtask

  task automatic random_packet();
    logic [PID_W-1:0] pid;
    logic [1:0]       field_ctl;
    logic [3:0]       cc;
    logic [7:0]       adapt_len;
    int               pick;
    int               words;
    sender_gaps = $urandom_range(0, 4) != 0;
    reader_gaps = $urandom_range(0, 4) != 0;
    pid = ($urandom_range(0, 9) < 7) ? pid_now : PID_W'($urandom);
    field_ctl = {1'($urandom), $urandom_range(0, 4) != 0};
    cc = ($urandom_range(0, 3) != 0) ? cc_next : 4'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 6) adapt_len = 8'($urandom_range(0, 20));
    else if (pick < 8) adapt_len = 8'($urandom_range(178, 186));
    else adapt_len = 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 6) words = PACKET_BYTES;
    else if (pick < 9) words = $urandom_range(1, 12);
    else words = $urandom_range(13, PACKET_BYTES - 1);
    send_packet(pid, $urandom_range(0, 9) == 0, 1'($urandom), field_ctl, cc, adapt_len, words,
                $urandom_range(0, 9) != 0);
    cc_next = cc + 4'd1;
  endtask

  task automatic random_phase(input int budget);
    int start;
    start = words_sent;
    while (words_sent - start < budget) random_packet();
  endtask

  initial begin : reader
    int gap;
    m_axis_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = reader_gaps ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_WANTED_PID;
    cfg_data = '0;
    sender_gaps = 1'b1;
    reader_gaps = 1'b1;
    pid_now = WANTED_PID_RESET;
    cc_next = '0;
    words_sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The first packet carries no start marker and must still be taken from byte 0.
    send_packet(WANTED_PID_RESET, 1'b0, 1'b1, 2'b01, 4'd5, 8'd0, PACKET_BYTES, 1'b0);
    // Longest adaptation field that still leaves the last byte as payload.
    send_packet(WANTED_PID_RESET, 1'b0, 1'b0, 2'b11, 4'd6, 8'd182, PACKET_BYTES, 1'b1);
    // Adaptation field that runs past the end of the packet, cut short.
    send_packet(WANTED_PID_RESET, 1'b0, 1'b1, 2'b11, 4'd7, 8'd183, 10, 1'b1);
    // Foreign PID and transport error, both with counters that must be ignored.
    send_packet(WANTED_PID_RESET ^ 13'h1, 1'b0, 1'b1, 2'b01, 4'd0, 8'd0, 6, 1'b1);
    send_packet(WANTED_PID_RESET, 1'b1, 1'b1, 2'b01, 4'd0, 8'd0, 6, 1'b1);
    // No payload, and a counter jump from 7 to 9.
    send_packet(WANTED_PID_RESET, 1'b0, 1'b1, 2'b10, 4'd9, 8'd0, 6, 1'b1);
    // A packet cut short and abandoned by the next start marker.
    send_packet(WANTED_PID_RESET, 1'b0, 1'b1, 2'b11, 4'd10, 8'd255, 5, 1'b1);
    cc_next = 4'd11;

    settle();
    write_reg(REG_WANTED_PID, PID_W'($urandom));
    random_phase(RANDOM_WORDS);

    settle();
    write_reg(REG_PID_FILTER_ENABLE, CFG_DATA_W'(0));
    write_reg(REG_WANTED_PID, '0);
    random_phase(RANDOM_WORDS);

    settle();
    write_reg(REG_PID_FILTER_ENABLE, CFG_DATA_W'(1));
    write_reg(REG_WANTED_PID, '1);
    random_phase(RANDOM_WORDS);

    s_axis_tvalid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0 && results_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/tspe_pkg.sv
sv/tspe_parser.sv
sv/ts_packet_payload_extractor.sv
verif/ts_packet_payload_extractor_checker.sv
verif/tb_ts_packet_payload_extractor.sv
